@@ design/upt_pkg.sv @@
package upt_pkg;

    localparam int COORD_W   = 32;
    localparam int FRAC_W    = 32;
    localparam int CELL_W    = 24;
    localparam int NUM_VERTS = 4;
    localparam int NUM_AXES  = 3;
    localparam int NUM_EDGES = 3;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef logic        [1:0]           t_vidx;
    typedef logic signed [COORD_W-1:0]   t_coord;
    typedef logic signed [COORD_W:0]     t_edge;
    typedef logic signed [COORD_W+1:0]   t_prod;
    typedef logic signed [COORD_W+2:0]   t_psum;
    typedef logic signed [COORD_W+3:0]   t_sum;
    typedef logic        [FRAC_W-1:0]    t_frac;
    typedef logic        [FRAC_W:0]      t_weight;
    typedef logic        [CELL_W-1:0]    t_cell;

    localparam t_weight FRAC_ONE  = {1'b1, {FRAC_W{1'b0}}};
    localparam t_coord  COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam t_coord  COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef struct packed {
        logic en_mul;
        logic en_add;
        logic en_out;
    } t_lane_ctl;

endpackage

@@ design/upt_ifs.sv @@
interface upt_in_if import upt_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   op;
    t_vidx  vertex_index;
    t_coord vertex_x;
    t_coord vertex_y;
    t_coord vertex_z;
    t_frac  rand_a;
    t_frac  rand_b;
    t_frac  rand_c;

    modport source (
        output valid, op, vertex_index, vertex_x, vertex_y, vertex_z,
               rand_a, rand_b, rand_c,
        input  ready
    );
    modport sink (
        input  valid, op, vertex_index, vertex_x, vertex_y, vertex_z,
               rand_a, rand_b, rand_c,
        output ready
    );
endinterface

interface upt_out_if import upt_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord point_x;
    t_coord point_y;
    t_coord point_z;
    t_cell  cell_id;

    modport source (
        output valid, point_x, point_y, point_z, cell_id,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, point_z, cell_id,
        output ready
    );
endinterface

interface upt_cfg_if import upt_pkg::*; ();
    logic  valid;
    logic  ready;
    t_cell data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

@@ design/upt_lane.sv @@
module upt_lane import upt_pkg::*; (
    input  logic      i_clk,
    input  t_lane_ctl i_ctl,
    input  t_coord    i_a,
    input  t_edge     i_e [NUM_EDGES],
    input  t_weight   i_w [NUM_EDGES],
    output t_coord    o_point
);

    logic signed [COORD_W+FRAC_W+1:0] prod [NUM_EDGES];
    t_prod  n_q [NUM_EDGES];
    t_prod  r_q [NUM_EDGES];
    t_coord r_a4;
    t_psum  r_sa;
    t_psum  r_sb;
    t_sum   total;
    t_coord n_pt;
    t_coord r_pt;

    // weight of exactly one passes the edge through unchanged
    always_comb begin
        for (int j = 0; j < NUM_EDGES; j++) begin
            prod[j] = i_e[j] * $signed({1'b0, i_w[j][FRAC_W-1:0]});
            if (i_w[j][FRAC_W]) begin
                n_q[j] = {i_e[j][COORD_W], i_e[j]};
            end else begin
                n_q[j] = prod[j][COORD_W+FRAC_W+1:FRAC_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_mul) begin
            r_q  <= n_q;
            r_a4 <= i_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_add) begin
            r_sa <= {{3{r_a4[COORD_W-1]}}, r_a4} + {r_q[0][COORD_W+1], r_q[0]};
            r_sb <= {r_q[1][COORD_W+1], r_q[1]} + {r_q[2][COORD_W+1], r_q[2]};
        end
    end

    // saturate to the coordinate range
    always_comb begin
        total = {r_sa[COORD_W+2], r_sa} + {r_sb[COORD_W+2], r_sb};
        if ((&total[COORD_W+3:COORD_W-1]) || !(|total[COORD_W+3:COORD_W-1])) begin
            n_pt = total[COORD_W-1:0];
        end else if (total[COORD_W+3]) begin
            n_pt = COORD_MIN;
        end else begin
            n_pt = COORD_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_out) begin
            r_pt <= n_pt;
        end
    end

    assign o_point = r_pt;

endmodule

@@ design/uniform_point_in_tetrahedron_core.sv @@
// uniform point in a tetrahedron
// i_in carries two kinds of request: a load (op = 0) writes vertex_index
// (0 is the anchor A, 1..3 are B, C, D) with vertex_x/y/z; a sample (op = 1)
// carries three fractions rand_a/b/c in unsigned 0.32 and yields one point
// A + w0*(B-A) + w1*(C-A) + w2*(D-A) on o_out, with cell_id from tetra_id.
// Loads produce nothing on o_out. All four vertices must be loaded before
// the first sample. i_cfg writes tetra_id; write it only while idle.
// Throughput: one request per cycle while o_out.ready stays high.
// Six register stages: capture of edges, pair fold, triple fold, multiply,
// partial sums, final sum with saturation. The multiply stage (33 x 32 bits
// per edge and axis) sets the clock.
// A load taken in the cycle before a sample is already seen by that sample.
// Reset (i_rst_n, synchronous, active low) empties the pipeline and clears
// tetra_id to zero; the vertex table is not cleared.
// When o_out.ready is low the pipeline closes its gaps and then holds;
// i_in.ready falls once every stage holds a sample. Nothing is dropped.
module uniform_point_in_tetrahedron_core import upt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    upt_in_if.sink    i_in,
    upt_cfg_if.sink   i_cfg,
    upt_out_if.source o_out
);

    t_coord  r_vtx [NUM_VERTS][NUM_AXES];
    t_cell   r_tetra_id;

    logic    r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic    en1, en2, en3, en4, en5, en6;
    logic    in_fire;

    t_coord  r_a1 [NUM_AXES];
    t_edge   r_e1 [NUM_AXES][NUM_EDGES];
    t_frac   r_r1 [3];
    t_coord  r_a2 [NUM_AXES];
    t_edge   r_e2 [NUM_AXES][NUM_EDGES];
    t_frac   r_f0, r_f1, r_r2;
    t_coord  r_a3 [NUM_AXES];
    t_edge   r_e3 [NUM_AXES][NUM_EDGES];
    t_weight r_w3 [NUM_EDGES];

    t_coord  coord_in [NUM_AXES];
    t_edge   n_e1 [NUM_AXES][NUM_EDGES];
    t_weight pair_sum;
    t_weight d0, d1;
    t_frac   n_f0, n_f1;
    logic [FRAC_W+1:0] tri_sum, tri_over;
    t_weight tail_sum;
    t_weight n_w [NUM_EDGES];
    t_lane_ctl lane_ctl;
    t_coord  point [NUM_AXES];

    // stall handling: a stage moves when it is empty or the next one moves
    assign en6 = !r_v6 || o_out.ready;
    assign en5 = !r_v5 || en6;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign i_in.ready  = en1;
    assign in_fire     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tetra_id <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_tetra_id <= i_cfg.data;
        end
    end

    assign coord_in[0] = i_in.vertex_x;
    assign coord_in[1] = i_in.vertex_y;
    assign coord_in[2] = i_in.vertex_z;

    always_ff @(posedge i_clk) begin
        if (in_fire && i_in.op == OP_LOAD) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                r_vtx[i_in.vertex_index][k] <= coord_in[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_in.valid && i_in.op == OP_SAMPLE;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
            if (en6) r_v6 <= r_v5;
        end
    end

    // edge vectors from the anchor
    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            for (int j = 0; j < NUM_EDGES; j++) begin
                n_e1[k][j] = {r_vtx[j+1][k][COORD_W-1], r_vtx[j+1][k]}
                           - {r_vtx[0][k][COORD_W-1], r_vtx[0][k]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                r_a1[k] <= r_vtx[0][k];
            end
            r_e1    <= n_e1;
            r_r1[0] <= i_in.rand_a;
            r_r1[1] <= i_in.rand_b;
            r_r1[2] <= i_in.rand_c;
        end
    end

    // pair fold
    always_comb begin
        pair_sum = {1'b0, r_r1[0]} + {1'b0, r_r1[1]};
        d0 = FRAC_ONE - {1'b0, r_r1[0]};
        d1 = FRAC_ONE - {1'b0, r_r1[1]};
        if (pair_sum > FRAC_ONE) begin
            n_f0 = d0[FRAC_W-1:0];
            n_f1 = d1[FRAC_W-1:0];
        end else begin
            n_f0 = r_r1[0];
            n_f1 = r_r1[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_a2 <= r_a1;
            r_e2 <= r_e1;
            r_f0 <= n_f0;
            r_f1 <= n_f1;
            r_r2 <= r_r1[2];
        end
    end

    // triple fold
    always_comb begin
        tri_sum  = {2'b00, r_f0} + {2'b00, r_f1} + {2'b00, r_r2};
        tri_over = tri_sum - {1'b0, FRAC_ONE};
        tail_sum = {1'b0, r_f1} + {1'b0, r_r2};
        if (tri_sum > {1'b0, FRAC_ONE}) begin
            if (tail_sum < FRAC_ONE) begin
                n_w[0] = FRAC_ONE - tail_sum;
                n_w[1] = {1'b0, r_f1};
                n_w[2] = tri_over[FRAC_W:0];
            end else begin
                n_w[0] = {1'b0, r_f0};
                n_w[1] = FRAC_ONE - {1'b0, r_r2};
                n_w[2] = FRAC_ONE - {1'b0, r_f0} - {1'b0, r_f1};
            end
        end else begin
            n_w[0] = {1'b0, r_f0};
            n_w[1] = {1'b0, r_f1};
            n_w[2] = {1'b0, r_r2};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_a3 <= r_a2;
            r_e3 <= r_e2;
            r_w3 <= n_w;
        end
    end

    assign lane_ctl.en_mul = en4;
    assign lane_ctl.en_add = en5;
    assign lane_ctl.en_out = en6;

    for (genvar k = 0; k < NUM_AXES; k++) begin : g_lane
        upt_lane u_lane (
            .i_clk   (i_clk),
            .i_ctl   (lane_ctl),
            .i_a     (r_a3[k]),
            .i_e     (r_e3[k]),
            .i_w     (r_w3),
            .o_point (point[k])
        );
    end

    assign o_out.valid   = r_v6;
    assign o_out.point_x = point[0];
    assign o_out.point_y = point[1];
    assign o_out.point_z = point[2];
    assign o_out.cell_id = r_tetra_id;

`ifndef NO_ASSERTIONS
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in.op == OP_LOAD) |=> !r_v1)
        else $error("load entered the sample pipeline");

    a_sample_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in.op == OP_SAMPLE) |=> r_v1)
        else $error("accepted sample lost at entry");

    a_pair_folded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (({1'b0, r_f0} + {1'b0, r_f1}) <= FRAC_ONE))
        else $error("pair fold left sum above one");

    a_weights_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> (({2'b00, r_w3[0]} + {2'b00, r_w3[1]} + {2'b00, r_w3[2]})
                  <= {2'b00, FRAC_ONE}))
        else $error("barycentric weights sum above one");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_v1 || r_v2 || r_v3 || r_v4 || r_v5 || r_v6) |-> i_in.ready)
        else $error("empty pipeline refused a request");
`endif

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import upt_pkg::*;

    localparam int    CLK_HALF     = 6;
    localparam int    RESET_CYCLES = 11;
    localparam int    DRAIN_CYCLES = 12;
    localparam int    HOLD_CYCLES  = 300;
    localparam longint LIMIT_CYCLES = 200000;

    typedef struct {
        t_coord x;
        t_coord y;
        t_coord z;
        t_cell  id;
    } t_point;

    class point_tracker;
        t_coord vertex [NUM_VERTS][NUM_AXES];
        t_cell  cell_id;
        t_point pending_points [$];
        int     mismatches;
        int     loads;
        int     samples;
        int     points_seen;
        int     pair_folds;
        int     triple_folds;
        int     saturated;
        int     id_writes;

        function new();
            cell_id      = '0;
            mismatches   = 0;
            loads        = 0;
            samples      = 0;
            points_seen  = 0;
            pair_folds   = 0;
            triple_folds = 0;
            saturated    = 0;
            id_writes    = 0;
        endfunction

        task report_mismatch(string what);
            if (mismatches < 20) begin
                $display("mismatch at %0t: %s", $realtime, what);
            end
            mismatches++;
        endtask

        function t_point predict_point(t_frac ra, t_frac rb, t_frac rc);
            t_point             p;
            logic [63:0]        one;
            logic [63:0]        r0;
            logic [63:0]        r1;
            logic [63:0]        r2;
            logic [63:0]        w [NUM_EDGES];
            logic signed [71:0] anchor;
            logic signed [71:0] corner;
            logic signed [71:0] prod;
            logic signed [71:0] acc;
            t_coord             res [NUM_AXES];
            one = 64'd1 << FRAC_W;
            r0  = 64'(ra);
            r1  = 64'(rb);
            r2  = 64'(rc);
            if (r0 + r1 > one) begin
                r0 = one - r0;
                r1 = one - r1;
                pair_folds++;
            end
            if (r0 + r1 + r2 > one) begin
                triple_folds++;
                if (r1 + r2 < one) begin
                    w[0] = one - r1 - r2;
                    w[1] = r1;
                    w[2] = r0 + r1 + r2 - one;
                end else begin
                    w[0] = r0;
                    w[1] = one - r2;
                    w[2] = one - r0 - r1;
                end
            end else begin
                w[0] = r0;
                w[1] = r1;
                w[2] = r2;
            end
            for (int k = 0; k < NUM_AXES; k++) begin
                anchor = vertex[0][k];
                acc    = anchor;
                for (int j = 0; j < NUM_EDGES; j++) begin
                    corner = vertex[j + 1][k];
                    prod   = (corner - anchor) * $signed({8'd0, w[j]});
                    acc    = acc + (prod >>> FRAC_W);
                end
                if (acc > COORD_MAX) begin
                    res[k] = COORD_MAX;
                    saturated++;
                end else if (acc < COORD_MIN) begin
                    res[k] = COORD_MIN;
                    saturated++;
                end else begin
                    res[k] = t_coord'(acc);
                end
            end
            p.x  = res[0];
            p.y  = res[1];
            p.z  = res[2];
            p.id = cell_id;
            return p;
        endfunction

        function void note_request(logic op, t_vidx idx, t_coord x, t_coord y, t_coord z,
                                   t_frac ra, t_frac rb, t_frac rc);
            if (op == OP_LOAD) begin
                vertex[idx][0] = x;
                vertex[idx][1] = y;
                vertex[idx][2] = z;
                loads++;
            end else begin
                pending_points.push_back(predict_point(ra, rb, rc));
                samples++;
            end
        endfunction

        task check_point(t_coord x, t_coord y, t_coord z, t_cell id);
            t_point want;
            if (pending_points.size() == 0) begin
                report_mismatch($sformatf("point %h %h %h id %h with no sample pending",
                                          x, y, z, id));
                return;
            end
            want = pending_points.pop_front();
            points_seen++;
            if (x !== want.x)
                report_mismatch($sformatf("point_x got %h want %h", x, want.x));
            if (y !== want.y)
                report_mismatch($sformatf("point_y got %h want %h", y, want.y));
            if (z !== want.z)
                report_mismatch($sformatf("point_z got %h want %h", z, want.z));
            if (id !== want.id)
                report_mismatch($sformatf("cell_id got %h want %h", id, want.id));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    upt_in_if  in_if ();
    upt_cfg_if cfg_if ();
    upt_out_if out_if ();

    point_tracker tracker = new();

    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    bit hold_request = 1'b0;
    bit hold_taken   = 1'b0;
    int hold_left    = 0;

    uniform_point_in_tetrahedron_core i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if.sink),
        .i_cfg   (cfg_if.sink),
        .o_out   (out_if.source)
    );

    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    function automatic t_coord pick_coord();
        case ($urandom_range(7))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return t_coord'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
            3: return COORD_MAX - t_coord'($urandom_range(0, 15));
            4: return COORD_MIN + t_coord'($urandom_range(0, 15));
            default: return t_coord'($urandom());
        endcase
    endfunction

    function automatic t_frac pick_frac();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return t_frac'($urandom_range(0, 15));
            3: return t_frac'(32'h8000_0000 + $urandom_range(0, 6) - 3);
            default: return t_frac'($urandom());
        endcase
    endfunction

    task automatic send_request(logic op, t_vidx idx, t_coord x, t_coord y, t_coord z,
                                t_frac ra, t_frac rb, t_frac rc);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid        <= 1'b1;
        in_if.op           <= op;
        in_if.vertex_index <= idx;
        in_if.vertex_x     <= x;
        in_if.vertex_y     <= y;
        in_if.vertex_z     <= z;
        in_if.rand_a       <= ra;
        in_if.rand_b       <= rb;
        in_if.rand_c       <= rc;
        do @(posedge clk); while (!in_if.ready);
        tracker.note_request(op, idx, x, y, z, ra, rb, rc);
    endtask

    // rand fields are don't-care on a load
    task automatic send_load(t_vidx idx, t_coord x, t_coord y, t_coord z);
        send_request(OP_LOAD, idx, x, y, z, t_frac'($urandom()), t_frac'($urandom()),
                     t_frac'($urandom()));
    endtask

    // vertex fields are don't-care on a sample
    task automatic send_sample(t_frac ra, t_frac rb, t_frac rc);
        send_request(OP_SAMPLE, t_vidx'($urandom_range(3)), t_coord'($urandom()),
                     t_coord'($urandom()), t_coord'($urandom()), ra, rb, rc);
    endtask

    task automatic send_random(int count, int load_pct);
        t_frac ra;
        t_frac rb;
        t_frac rc;
        repeat (count) begin
            if ($urandom_range(99) < load_pct) begin
                send_load(t_vidx'($urandom_range(3)), pick_coord(), pick_coord(), pick_coord());
            end else begin
                ra = pick_frac();
                rb = pick_frac();
                rc = pick_frac();
                // land exactly on the fold boundaries now and then
                case ($urandom_range(5))
                    0: rb = t_frac'(0) - ra;
                    1: rc = t_frac'(0) - rb;
                    default: ;
                endcase
                send_sample(ra, rb, rc);
            end
        end
    endtask

    task automatic wait_until_drained();
        in_if.valid <= 1'b0;
        while (tracker.pending_points.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_tetra_id(t_cell value);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        do @(posedge clk); while (!cfg_if.ready);
        tracker.cell_id = value;
        tracker.id_writes++;
        cfg_if.valid <= 1'b0;
    endtask

    initial begin
        forever begin
            @(posedge clk);
            if (rst_n && out_if.valid && out_if.ready) begin
                tracker.check_point(out_if.point_x, out_if.point_y, out_if.point_z,
                                    out_if.cell_id);
            end
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_if.ready <= 1'b0;
                hold_left--;
            end else begin
                out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        rst_n              <= 1'b0;
        in_if.valid        <= 1'b0;
        in_if.op           <= OP_LOAD;
        in_if.vertex_index <= '0;
        in_if.vertex_x     <= '0;
        in_if.vertex_y     <= '0;
        in_if.vertex_z     <= '0;
        in_if.rand_a       <= '0;
        in_if.rand_b       <= '0;
        in_if.rand_c       <= '0;
        cfg_if.valid       <= 1'b0;
        cfg_if.data        <= '0;
        out_if.ready       <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extreme vertices, fold boundaries, low saturation, reset id
        send_load(2'd3, COORD_MIN, t_coord'(-1), t_coord'(1));
        send_load(2'd2, COORD_MIN, t_coord'(0), COORD_MIN);
        send_load(2'd1, COORD_MIN, COORD_MIN, COORD_MAX);
        send_load(2'd0, COORD_MIN + t_coord'(1), COORD_MAX, t_coord'(0));
        send_sample(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_sample(32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
        send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_sample(32'h8000_0000, 32'h8000_0000, 32'h0000_0000);
        send_sample(32'hC000_0000, 32'hC000_0000, 32'h0000_0000);
        send_sample(32'h4000_0000, 32'h4000_0000, 32'h8000_0000);
        send_sample(32'h8000_0000, 32'h2000_0000, 32'h7000_0000);
        send_sample(32'h1000_0000, 32'h8000_0000, 32'h8000_0000);
        send_sample(32'h2000_0000, 32'hC000_0000, 32'hF000_0000);
        send_sample(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
        send_load(2'd0, COORD_MAX, COORD_MIN, COORD_MAX);
        send_sample(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
        send_load(2'd2, COORD_MAX, COORD_MAX, COORD_MIN);
        send_sample(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);

        wait_until_drained();
        write_tetra_id(24'hFF_FFFF);
        tx_idle_pct = 31;
        rx_idle_pct = 50;
        send_random(350, 25);

        wait_until_drained();
        write_tetra_id(t_cell'($urandom()));
        tx_idle_pct = 50;
        rx_idle_pct = 31;
        send_random(350, 25);

        wait_until_drained();
        write_tetra_id(24'h00_0000);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_random(350, 25);

        // long output stall while requests keep coming
        wait_until_drained();
        write_tetra_id(t_cell'($urandom()));
        hold_request = 1'b1;
        send_random(150, 10);

        in_if.valid <= 1'b0;
        while (tracker.pending_points.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.pending_points.size() != 0) begin
            tracker.report_mismatch($sformatf("%0d samples never produced a point",
                                              tracker.pending_points.size()));
        end

        $display("covered %0d vertex loads, %0d samples, %0d points checked, %0d tetra_id writes",
                 tracker.loads, tracker.samples, tracker.points_seen, tracker.id_writes);
        $display("weights: %0d pair folds, %0d triple folds; %0d saturated coordinates",
                 tracker.pair_folds, tracker.triple_folds, tracker.saturated);
        if (tracker.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/upt_pkg.sv
design/upt_ifs.sv
design/upt_lane.sv
design/uniform_point_in_tetrahedron_core.sv
verif/testbench.sv
